[hdl/pdc_pkg.sv]
// ---------------------------------------------------------------------------
// pdc_pkg: shared types and constants for the packet deframer
// Byte codes, phase codes, result kinds and the result record that moves
// from the front end through the queue to the output stage.
// ---------------------------------------------------------------------------
package pdc_pkg;

  // Framing
  localparam logic [7:0] START_MARKER = 8'h3E;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ANY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_CMD = 2'd1;

  // Receive phases
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_HSUM = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_PSUM = 3'd5;

  // Result kinds
  localparam logic [2:0] K_DATA  = 3'd0;
  localparam logic [2:0] K_GOOD  = 3'd1;
  localparam logic [2:0] K_STRAY = 3'd2;
  localparam logic [2:0] K_HERR  = 3'd3;
  localparam logic [2:0] K_PERR  = 3'd4;

  // Queue between front end and output stage
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] packet_cmd;
    logic [7:0] data_byte;
    logic [7:0] payload_len;
  } result_t;

endpackage

[hdl/pdc_if.sv]
// ---------------------------------------------------------------------------
// pdc_if: valid/ready channels of the packet deframer
// Byte input channel and result output channel.
// ---------------------------------------------------------------------------
interface pdc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pdc_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] packet_cmd;
  logic [7:0] data_byte;
  logic [7:0] payload_len;

  modport source (output valid, output kind, output packet_cmd, output data_byte,
                  output payload_len, input ready);
  modport sink   (input valid, input kind, input packet_cmd, input data_byte,
                  input payload_len, output ready);
endinterface

[hdl/pdc_front.sv]
// ---------------------------------------------------------------------------
// pdc_front: byte classifier
// Takes one byte per transfer, tracks the frame phase and the checksums,
// and pushes at most one result record into the queue for each byte.
// ---------------------------------------------------------------------------
module pdc_front import pdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pdc_byte_if.sink              rx,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  push,
  output result_t               push_data
);

  logic       match_any;
  logic       wanted_cmd_en;
  logic [7:0] wanted_cmd;

  logic [2:0] phase, phase_next;
  logic [7:0] cmd_seen, cmd_seen_next;
  logic [7:0] payload_length, payload_length_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic       deliver_flag, deliver_flag_next;

  logic       fire;
  logic [7:0] b;
  logic [7:0] hsum;
  logic [7:0] left_dec;

  // Accept whenever the queue has room
  assign rx.ready = !q_full;
  assign fire     = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  assign hsum     = 8'(cmd_seen + payload_length);
  assign left_dec = 8'(bytes_left - 8'd1);
  assign wanted_cmd_en = cfg_we && (cfg_index == CFG_WANTED_CMD);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_any  <= 1'b1;
      wanted_cmd <= 8'd0;
    end else begin
      if (cfg_we && (cfg_index == CFG_MATCH_ANY)) match_any <= cfg_data[0];
      if (wanted_cmd_en) wanted_cmd <= cfg_data[7:0];
    end
  end

  // Phase decode and result generation
  always_comb begin
    phase_next          = phase;
    cmd_seen_next       = cmd_seen;
    payload_length_next = payload_length;
    bytes_left_next     = bytes_left;
    running_sum_next    = running_sum;
    deliver_flag_next   = deliver_flag;
    push                = 1'b0;
    push_data.kind        = K_STRAY;
    push_data.packet_cmd  = cmd_seen;
    push_data.data_byte   = b;
    push_data.payload_len = payload_length;

    unique case (phase)
      PH_CMD: begin
        cmd_seen_next = b;
        phase_next    = PH_LEN;
      end
      PH_LEN: begin
        payload_length_next = b;
        bytes_left_next     = b;
        phase_next          = PH_HSUM;
      end
      PH_HSUM: begin
        if (b != hsum) begin
          phase_next     = PH_HUNT;
          push           = 1'b1;
          push_data.kind = K_HERR;
        end else begin
          running_sum_next  = 8'd0;
          deliver_flag_next = match_any || (cmd_seen == wanted_cmd);
          phase_next        = (bytes_left != 8'd0) ? PH_DATA : PH_PSUM;
        end
      end
      PH_DATA: begin
        running_sum_next = 8'(running_sum + b);
        bytes_left_next  = left_dec;
        if (left_dec == 8'd0) phase_next = PH_PSUM;
        push           = deliver_flag;
        push_data.kind = K_DATA;
      end
      PH_PSUM: begin
        phase_next = PH_HUNT;
        if (b != running_sum) begin
          push           = 1'b1;
          push_data.kind = K_PERR;
        end else begin
          push           = deliver_flag;
          push_data.kind = K_GOOD;
        end
      end
      default: begin
        // hunting: marker opens a frame, anything else is stray
        if (b == START_MARKER) begin
          phase_next = PH_CMD;
        end else begin
          phase_next            = PH_HUNT;
          push                  = 1'b1;
          push_data.kind        = K_STRAY;
          push_data.packet_cmd  = 8'd0;
          push_data.payload_len = 8'd0;
        end
      end
    endcase

    // nothing moves without a transfer
    if (!fire) push = 1'b0;
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      cmd_seen       <= 8'd0;
      payload_length <= 8'd0;
      bytes_left     <= 8'd0;
      running_sum    <= 8'd0;
      deliver_flag   <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      cmd_seen       <= cmd_seen_next;
      payload_length <= payload_length_next;
      bytes_left     <= bytes_left_next;
      running_sum    <= running_sum_next;
      deliver_flag   <= deliver_flag_next;
    end
  end

endmodule

[hdl/pdc_queue.sv]
// ---------------------------------------------------------------------------
// pdc_queue: short result queue
// Small FIFO of result records between the classifier and the output stage.
// ---------------------------------------------------------------------------
module pdc_queue import pdc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  input  logic    pop,
  output result_t pop_data,
  output logic    empty
);

  result_t              slots [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign full     = (count == Q_CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : Q_PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : Q_PTR_W'(rd_ptr + 1'b1);
      end
      unique case ({push, pop})
        2'b10:   count <= Q_CNT_W'(count + 1'b1);
        2'b01:   count <= Q_CNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/pdc_back.sv]
// ---------------------------------------------------------------------------
// pdc_back: result output stage
// Registered output that drains the queue one record per transfer.
// ---------------------------------------------------------------------------
module pdc_back import pdc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    empty,
  input  result_t pop_data,
  output logic    pop,
  pdc_res_if.source tx
);

  logic    out_valid;
  result_t out_data;

  // Load when the register is free or being taken this cycle
  assign pop = !empty && (!out_valid || tx.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || tx.ready) begin
      out_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= pop_data;
  end

  assign tx.valid       = out_valid;
  assign tx.kind        = out_data.kind;
  assign tx.packet_cmd  = out_data.packet_cmd;
  assign tx.data_byte   = out_data.data_byte;
  assign tx.payload_len = out_data.payload_len;

endmodule

[hdl/packet_deframer_checksum.sv]
// Result path: a byte that yields a result is written to the result queue at
//   its transfer on rx, then loaded into the output register, and shows on tx.
// Throughput: one byte per cycle; rx stalls only while the two-entry result
//   queue is full, which follows from tx back-pressure.
// Reset (rst, synchronous): hunting for the marker, queue and output empty,
//   match_any = 1, wanted_cmd = 0.
// ---------------------------------------------------------------------------
// packet_deframer_checksum: serial packet deframer with checksums
// Hunts for the start marker, checks header and payload sums, delivers payload
// bytes and the good end of selected packets, and sum errors and stray bytes.
// ---------------------------------------------------------------------------
module packet_deframer_checksum import pdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pdc_byte_if.sink              rx,
  pdc_res_if.source             tx,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  result_t push_data;
  result_t pop_data;

  // Classifier
  pdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue
  pdc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Output stage
  pdc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (q_empty),
    .pop_data (pop_data),
    .pop      (pop),
    .tx       (tx)
  );

endmodule

[hdl/pdc_checker.sv]
// ---------------------------------------------------------------------------
// pdc_checker: port-level checks for the packet deframer
// Watches the top-level ports and flags illegal result behavior.
// ---------------------------------------------------------------------------
module pdc_checker import pdc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [7:0] packet_cmd,
  input logic [7:0] payload_len
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its kind
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind))
    else $error("stalled result changed");

  // Stray bytes carry no packet context
  a_stray: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_STRAY |-> packet_cmd == 8'd0 && payload_len == 8'd0)
    else $error("stray result with packet fields");

  // Only defined kinds leave the block
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == K_DATA || kind == K_GOOD || kind == K_STRAY ||
                  kind == K_HERR || kind == K_PERR)
    else $error("undefined result kind");

  // Input accepts while the output is idle (the queue cannot be full then)
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid && $past(!out_valid) && !$past(rst) |-> in_ready)
    else $error("input stalled with idle output");

endmodule

bind packet_deframer_checksum pdc_checker u_pdc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (rx.ready),
  .out_valid   (tx.valid),
  .out_ready   (tx.ready),
  .kind        (tx.kind),
  .packet_cmd  (tx.packet_cmd),
  .payload_len (tx.payload_len)
);
